@@ rtl/pkte_pkg.sv @@
// pkte_pkg: shared types, constants and helper functions for the per-key trust table.
// Used by pkte_ctrl, pkte_dp and per_key_trust_ema_table; depends on nothing.
`timescale 1ns / 1ps
package pkte_pkg;

	typedef enum logic [1:0] {
		CMD_OBSERVE  = 2'd0,
		CMD_CHECK    = 2'd1,
		CMD_NOTE_ALR = 2'd2,
		CMD_NOTE_SUP = 2'd3
	} cmd_t;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_AGE    = 2'd1;
	localparam logic [1:0] REG_MINCNT = 2'd2;

	localparam logic [16:0] Q_ONE          = 17'd65536;
	localparam logic [16:0] ALPHA_Q        = 17'd7864;
	localparam logic [16:0] KEEP_Q         = 17'd57672;
	localparam logic [16:0] PARTIAL_Q      = 17'd42599;
	localparam logic [16:0] FULL_Q         = 17'd53740;
	localparam logic [16:0] CRIT_Q         = 17'd57672;
	localparam logic [16:0] TENANT_BOOST_Q = 17'd52429;
	localparam logic [16:0] DECAY_Q        = 17'd55706;
	localparam logic [16:0] FLOOR_Q        = 17'd6554;
	localparam logic [16:0] TENANT_RESET_Q = 17'd32768;
	localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;
	localparam logic [31:0] FNV_BASIS      = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME      = 32'd16777619;
	localparam logic [13:0] TECH_BRUTE     = 14'd1110;
	localparam logic [13:0] TECH_DECODE    = 14'd1083;
	localparam logic [13:0] TECH_DOS       = 14'd1499;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic        key_valid;
		logic [39:0] now_seconds;
		logic [9:0]  status_code;
		logic [1:0]  alert_level;
		logic [13:0] technique;
		logic        never_suppress;
	} in_item_t;

	typedef struct packed {
		logic        entry_found;
		logic        suppress;
		logic [1:0]  boost_code;
		logic        trusted_flag;
		logic        partial_flag;
		logic [16:0] clean_score;
		logic [16:0] tenant_score;
		logic [31:0] suppressed_count;
	} out_item_t;

	// one table row; used bits live elsewhere
	typedef struct packed {
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [16:0] score;
		logic [31:0] samples;
		logic [39:0] seen_at;
		logic        trusted;
		logic        partial;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture item, start hash
		logic hash_step;  // one byte of FNV, or a step of the index reduction
		logic probe_rd;   // read row/used at probe index
		logic probe_next; // advance probe index
		logic mul_a;      // first EMA product
		logic mul_b;      // second EMA product / decay product
		logic commit;     // write back row and tenant state
		logic emit;       // drive result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hash_done;
		logic slot_free;
		logic slot_match;
		logic probe_exhausted;
	} dp_stat_t;

	function automatic logic [16:0] benign(input logic [9:0] st);
		logic [16:0] r;
		r = 17'd32768;
		if (st >= 10'd200 && st < 10'd400) r = Q_ONE;
		else if (st == 10'd401 || st == 10'd403 || st == 10'd404) r = 17'd49152;
		else if (st >= 10'd500) r = 17'd9830;
		return r;
	endfunction

endpackage

@@ rtl/pkte_ctrl.sv @@
// pkte_ctrl: sequencer for hash, probe, update and result of one item.
// Depends on pkte_pkg.
`timescale 1ns / 1ps
module pkte_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                enable,
	input  logic [1:0]          command,
	input  logic                key_valid,
	input  logic                clr_done,
	input  pkte_pkg::dp_stat_t  stat,
	output logic                busy,
	output pkte_pkg::dp_cmd_t   cmd
);
	import pkte_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_HASH, ST_READ, ST_WAIT, ST_TEST,
		ST_MULA, ST_MULB, ST_COMMIT, ST_EMIT
	} state_t;

	state_t state_q;
	logic   lookup_q;

	always_comb begin
		cmd = '0;
		cmd.load       = (state_q == ST_IDLE) && start;
		cmd.hash_step  = (state_q == ST_HASH);
		cmd.probe_rd   = (state_q == ST_READ);
		cmd.probe_next = (state_q == ST_TEST) && !stat.slot_free && !stat.slot_match
			&& !stat.probe_exhausted;
		cmd.mul_a      = (state_q == ST_MULA);
		cmd.mul_b      = (state_q == ST_MULB);
		cmd.commit     = (state_q == ST_COMMIT);
		cmd.emit       = (state_q == ST_EMIT);
	end

	assign busy = (state_q != ST_IDLE);

	// advance through the sequence; a lookup-free item skips the probe states and goes straight to ST_MULA
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			lookup_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: if (clr_done) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (start) begin
						case (command)
							CMD_OBSERVE, CMD_CHECK: lookup_q <= enable && key_valid;
							default:                lookup_q <= key_valid;
						endcase
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (stat.hash_done) state_q <= lookup_q ? ST_READ : ST_MULA;
				end
				ST_READ: state_q <= ST_WAIT;
				ST_WAIT: state_q <= ST_TEST;
				ST_TEST: begin
					if (stat.slot_free || stat.slot_match || stat.probe_exhausted)
						state_q <= ST_MULA;
					else
						state_q <= ST_READ;
				end
				ST_MULA:   state_q <= ST_MULB;
				ST_MULB:   state_q <= ST_COMMIT;
				ST_COMMIT: state_q <= ST_EMIT;
				ST_EMIT:   state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !cmd.emit) else $error("emit longer than one cycle");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.load) else $error("load while busy");
	a_commit_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> cmd.emit) else $error("commit not followed by emit");
endmodule

@@ rtl/pkte_dp.sv @@
// pkte_dp: hash unit, table memories, probe counter, EMA arithmetic and tenant state.
// Depends on pkte_pkg.
`timescale 1ns / 1ps
module pkte_dp #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pkte_pkg::in_item_t   item,
	input  logic                 enable,
	input  logic [15:0]          trust_age_days,
	input  logic [15:0]          min_sample_count,
	input  pkte_pkg::dp_cmd_t    cmd,
	output pkte_pkg::dp_stat_t   stat,
	output logic                 clr_done,
	output pkte_pkg::out_item_t  res,
	output logic                 res_valid
);
	import pkte_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	// reciprocal of the table size, exact for every 32-bit hash
	localparam logic [63:0] RECIP = (64'd1 << (32 + IW)) / 64'(TABLE_ENTRIES) + 64'd1;

	// item and hash
	in_item_t    it_q;
	logic [31:0] hash_q;
	logic [3:0]  byte_q;
	logic        hash_last_q;
	logic        hash_done_q;
	logic [7:0]  cur_byte;
	logic [31:0] hx;
	logic        lookup_q;
	logic [31:0] quo_q;
	logic [65:0] recip_prod;
	logic [31:0] hash_rem;

	assign cur_byte = byte_q[3] ? it_q.key_low[8*(7-byte_q[2:0]) +: 8]
		: it_q.key_high[8*(7-byte_q[2:0]) +: 8];
	assign hx = hash_q ^ {24'd0, cur_byte};
	assign recip_prod = 66'(hash_q) * 66'(RECIP[33:0]);
	assign hash_rem = hash_q - 32'(quo_q * 32'(TABLE_ENTRIES));

	// memories and clearing pass
	entry_t      mem_q  [TABLE_ENTRIES];
	logic        used_q [TABLE_ENTRIES];
	entry_t      rd_q;
	logic        rd_used_q;
	logic [IW:0] clr_q;
	logic [IW-1:0] idx_q;
	logic [IW:0]   probes_q;
	logic        we;
	logic [IW-1:0] waddr;
	entry_t      wdata;

	assign clr_done = clr_q[IW];

	always_ff @(posedge clk) begin
		if (cmd.probe_rd) begin
			rd_q <= mem_q[idx_q];
		end
		if (we) mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (!clr_q[IW]) used_q[clr_q[IW-1:0]] <= 1'b0;
		else if (we) used_q[waddr] <= 1'b1;
		if (cmd.probe_rd) rd_used_q <= used_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (!clr_q[IW]) clr_q <= clr_q + 1'b1;
	end

	// hash one byte a cycle, then reduce it to a row index by reciprocal multiply
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q        <= item;
			hash_q      <= FNV_BASIS;
			byte_q      <= '0;
			hash_last_q <= 1'b0;
			hash_done_q <= 1'b0;
			lookup_q    <= 1'b0;
		end else if (cmd.hash_step && !hash_last_q) begin
			hash_q <= hx * FNV_PRIME;
			byte_q <= byte_q + 1'b1;
			if (byte_q == 4'd15) hash_last_q <= 1'b1;
		end else if (cmd.hash_step && !hash_done_q) begin
			quo_q       <= 32'(recip_prod >> (32 + IW));
			hash_done_q <= 1'b1;
		end
		if (cmd.hash_step && hash_done_q) begin
			idx_q    <= hash_rem[IW-1:0];
			probes_q <= '0;
		end else if (cmd.probe_next) begin
			idx_q    <= (idx_q == IW'(TABLE_ENTRIES - 1)) ? '0 : idx_q + 1'b1;
			probes_q <= probes_q + 1'b1;
		end
		if (cmd.probe_rd) lookup_q <= 1'b1;
	end

	logic match;
	assign match = rd_used_q && rd_q.key_high == it_q.key_high
		&& rd_q.key_low == it_q.key_low;

	assign stat.hash_done       = hash_done_q;
	assign stat.slot_free       = !rd_used_q;
	assign stat.slot_match      = match;
	assign stat.probe_exhausted = (probes_q == (IW+1)'(TABLE_ENTRIES - 1));

	// found entry, fresh if inserted
	logic   found_q;
	logic   fresh_q;
	entry_t ent_q;
	logic [16:0] s_q;
	logic [33:0] prod_a_q;
	logic [33:0] prod_b_q;
	logic [16:0] tprod_src;
	logic [33:0] tprod_a_q;
	logic [33:0] tprod_b_q;
	logic [56:0] age_need_q;

	logic [16:0] tenant_q;
	logic [31:0] tsamp_q;
	logic [31:0] supp_q;

	assign tprod_src = tenant_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_a) begin
			found_q <= lookup_q && (!rd_used_q || match);
			fresh_q <= !rd_used_q;
			if (!rd_used_q) begin
				ent_q.key_high   <= it_q.key_high;
				ent_q.key_low    <= it_q.key_low;
				ent_q.score      <= '0;
				ent_q.samples    <= '0;
				ent_q.seen_at    <= it_q.now_seconds;
				ent_q.trusted    <= 1'b0;
				ent_q.partial    <= 1'b0;
			end else begin
				ent_q <= rd_q;
			end
			s_q        <= benign(it_q.status_code);
			prod_a_q   <= ALPHA_Q * benign(it_q.status_code);
			tprod_a_q  <= 34'(KEEP_Q * tprod_src);
			age_need_q <= 57'(trust_age_days * SECONDS_PER_DAY);
		end
		if (cmd.mul_b) begin
			prod_b_q <= (it_q.command == CMD_NOTE_ALR) ? 34'(ent_q.score * DECAY_Q)
				: 34'(ent_q.score * KEEP_Q);
			tprod_b_q <= tprod_a_q + prod_a_q + 34'd32768;
		end
	end

	// commit: new entry state and result
	logic [34:0] ema_sum;
	logic [16:0] ema_new, decay_v, t_new;
	entry_t      upd;
	logic        age_ok;
	logic [39:0] age;
	logic        sup_c;
	logic [1:0]  boost_c;
	logic        do_obs, do_chk, do_alr;

	always_comb begin
		ema_sum = 35'(prod_a_q) + 35'(prod_b_q) + 35'd32768;
		ema_new = ema_sum[32:16];
		decay_v = 17'((prod_b_q + 34'd32768) >> 16);
		if (decay_v < FLOOR_Q) decay_v = FLOOR_Q;
		t_new   = (tsamp_q == '0) ? s_q : tprod_b_q[32:16];
		do_obs  = found_q && it_q.command == CMD_OBSERVE;
		do_chk  = found_q && it_q.command == CMD_CHECK;
		do_alr  = found_q && it_q.command == CMD_NOTE_ALR;
		upd     = ent_q;
		age     = it_q.now_seconds - ent_q.seen_at;
		age_ok  = trust_age_days == '0 || (ent_q.seen_at != '0
			&& it_q.now_seconds >= ent_q.seen_at && 57'(age) >= age_need_q);
		if (do_obs) begin
			upd.score   = (ent_q.samples == '0) ? s_q : ema_new;
			upd.samples = (ent_q.samples == '1) ? ent_q.samples : ent_q.samples + 1'b1;
			upd.partial = upd.samples >= 32'(min_sample_count >> 1) && upd.score >= PARTIAL_Q;
			upd.trusted = upd.samples >= 32'(min_sample_count) && upd.score >= FULL_Q
				&& age_ok;
		end else if (do_alr) begin
			upd.score   = decay_v;
			upd.partial = 1'b0;
			upd.trusted = 1'b0;
		end
		sup_c   = 1'b0;
		boost_c = 2'd0;
		if (do_chk) begin
			if (it_q.alert_level != 2'd0 && !it_q.never_suppress) begin
				if (it_q.alert_level <= 2'd2 && (ent_q.partial || ent_q.trusted)) sup_c = 1'b1;
				else if (it_q.alert_level == 2'd3 && ent_q.trusted && ent_q.score >= CRIT_Q
					&& (it_q.technique == TECH_BRUTE || it_q.technique == TECH_DECODE
					|| it_q.technique == TECH_DOS)) sup_c = 1'b1;
			end
			if (ent_q.trusted) boost_c = 2'd3;
			else if (ent_q.partial) boost_c = 2'd2;
			else if (tenant_q >= TENANT_BOOST_Q && tsamp_q > 32'(min_sample_count))
				boost_c = 2'd1;
		end
		we    = cmd.commit && found_q && (fresh_q || do_obs || do_alr);
		waddr = idx_q;
		wdata = upd;
	end

	// tenant state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tenant_q  <= TENANT_RESET_Q;
			tsamp_q   <= '0;
			supp_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (do_obs) begin
					tenant_q <= t_new;
					if (tsamp_q != '1) tsamp_q <= tsamp_q + 1'b1;
				end
				if (it_q.command == CMD_NOTE_SUP && supp_q != '1) supp_q <= supp_q + 1'b1;
			end
			res_valid <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res.entry_found  <= found_q;
			res.suppress     <= sup_c;
			res.boost_code   <= boost_c;
			res.trusted_flag <= found_q && enable && upd.trusted;
			res.partial_flag <= found_q && upd.partial;
			res.clean_score  <= found_q ? upd.score : '0;
			res.tenant_score <= do_obs ? t_new : tenant_q;
			res.suppressed_count <= (it_q.command == CMD_NOTE_SUP && supp_q != '1)
				? supp_q + 1'b1 : supp_q;
		end
	end

	a_write_found: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> found_q) else $error("write without a found entry");
	a_supp_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(supp_q) && $past(arst_n) |-> supp_q >= $past(supp_q))
		else $error("suppression total went down");
	a_tenant_range: assert property (@(posedge clk) disable iff (!arst_n)
		tenant_q <= Q_ONE) else $error("tenant EMA above one");
endmodule

@@ rtl/per_key_trust_ema_table.sv @@
// Per-key trust table with EMA scores.
// Usage: raise start with a command item while busy is low; the item is taken
// at that edge and busy rises. A config write (cfg_we, cfg_index, cfg_data)
// lands at the edge it is high. The user must write only while the block is
// idle; the block does not enforce it. Each item gives exactly one result,
// shown on result for one cycle with done high; the receiver cannot stall it.
// The FNV-1a hash runs one byte per cycle over the 16 key bytes, and each
// probe of a lookup costs one registered memory read of the table.
// One item is in flight at a time; start is taken again the cycle after done.
// After reset the table's used bits are cleared, one row per cycle, over all
// TABLE_ENTRIES rows; busy stays high during that pass. Config registers
// reset to enable 0, trust_age_days 30, min_sample_count 100; tenant EMA to
// one half, counters to zero.
`timescale 1ns / 1ps
module per_key_trust_ema_table #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pkte_pkg::in_item_t   item,
	output logic                 done,
	output pkte_pkg::out_item_t  result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);
	import pkte_pkg::*;

	logic        enable_q;
	logic [15:0] age_q;
	logic [15:0] mincnt_q;
	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic        clr_done;

	// hold config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			age_q    <= 16'd30;
			mincnt_q <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_AGE:    age_q    <= cfg_data;
				REG_MINCNT: mincnt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pkte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .enable(enable_q),
		.command(item.command), .key_valid(item.key_valid), .clr_done(clr_done),
		.stat(stat), .busy(busy), .cmd(cmd)
	);

	pkte_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .enable(enable_q),
		.trust_age_days(age_q), .min_sample_count(mincnt_q), .cmd(cmd),
		.stat(stat), .clr_done(clr_done), .res(result), .res_valid(done)
	);
endmodule

@@ bench/tb_per_key_trust_ema_table.sv @@
// Self-checking bench for per_key_trust_ema_table: directed and random command items,
// checked against a behavioral trust-table predictor. Depends on pkte_pkg and the RTL.
`timescale 1ns / 1ps
module tb_per_key_trust_ema_table;
	import pkte_pkg::*;

	localparam int ROWS = 4096;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t item = '0;
	logic done;
	out_item_t result;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_ENABLE;
	logic [15:0] cfg_data = '0;

	per_key_trust_ema_table DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Trust table predictor and store of expected results
	class TrustScoreboard;
		bit used [ROWS];
		bit [63:0] row_hi [ROWS];
		bit [63:0] row_lo [ROWS];
		bit [16:0] row_score [ROWS];
		bit [31:0] row_samples [ROWS];
		bit [39:0] row_first [ROWS];
		bit row_partial [ROWS];
		bit row_trusted [ROWS];
		bit [16:0] tenant_ema = 17'd32768;
		bit [31:0] tenant_samples = 0;
		bit [31:0] sup_total = 0;
		bit en = 0;
		bit [15:0] age_days = 16'd30;
		bit [15:0] min_count = 16'd100;
		out_item_t pending_results [$];
		int errors = 0;

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		function bit [31:0] fnv_hash(bit [63:0] hi, bit [63:0] lo);
			bit [31:0] h;
			bit [127:0] k;
			h = 32'd2166136261;
			k = {hi, lo};
			for (int i = 0; i < 16; i++) begin
				h ^= {24'd0, k[127 - 8 * i -: 8]};
				h = h * 32'd16777619;
			end
			return h;
		endfunction

		// find or insert; -1 when every row is taken by other keys
		function int lookup(bit [63:0] hi, bit [63:0] lo, bit [39:0] now);
			int idx;
			idx = int'(fnv_hash(hi, lo) % ROWS);
			for (int n = 0; n < ROWS; n++) begin
				if (!used[idx]) begin
					used[idx] = 1;
					row_hi[idx] = hi;
					row_lo[idx] = lo;
					row_score[idx] = 0;
					row_samples[idx] = 0;
					row_first[idx] = now;
					row_partial[idx] = 0;
					row_trusted[idx] = 0;
					return idx;
				end
				if (row_hi[idx] == hi && row_lo[idx] == lo)
					return idx;
				idx = (idx + 1) % ROWS;
			end
			return -1;
		endfunction

		function bit [16:0] blend(bit [16:0] old, bit [16:0] s);
			bit [63:0] acc;
			acc = 64'd7864 * s + 64'd57672 * old + 64'd32768;
			return acc[32:16];
		endfunction

		function bit [16:0] status_score(bit [9:0] st);
			if (st >= 200 && st < 400) return 17'd65536;
			if (st == 401 || st == 403 || st == 404) return 17'd49152;
			if (st >= 500) return 17'd9830;
			return 17'd32768;
		endfunction

		// note an accepted item and queue what it must produce
		function void note_item(in_item_t it);
			out_item_t r;
			int slot;
			bit [16:0] s;
			bit age_ok;
			bit [63:0] prod;
			slot = -1;
			r = '0;
			case (cmd_t'(it.command))
				CMD_OBSERVE: if (en && it.key_valid) begin
					slot = lookup(it.key_high, it.key_low, it.now_seconds);
					if (slot >= 0) begin
						s = status_score(it.status_code);
						row_score[slot] = row_samples[slot] == 0 ? s : blend(row_score[slot], s);
						if (row_samples[slot] != 32'hFFFFFFFF) row_samples[slot]++;
						age_ok = age_days == 0 || (row_first[slot] > 0 &&
							it.now_seconds >= row_first[slot] &&
							64'(it.now_seconds - row_first[slot]) >= 64'(age_days) * 86400);
						row_partial[slot] = row_samples[slot] >= 32'(min_count / 2) &&
							row_score[slot] >= PARTIAL_Q;
						row_trusted[slot] = row_samples[slot] >= 32'(min_count) &&
							row_score[slot] >= FULL_Q && age_ok;
						tenant_ema = tenant_samples == 0 ? s : blend(tenant_ema, s);
						if (tenant_samples != 32'hFFFFFFFF) tenant_samples++;
					end
				end
				CMD_CHECK: if (en && it.key_valid) begin
					slot = lookup(it.key_high, it.key_low, it.now_seconds);
					if (slot >= 0) begin
						if (it.alert_level != 0 && !it.never_suppress) begin
							if (it.alert_level <= 2 && (row_partial[slot] || row_trusted[slot]))
								r.suppress = 1;
							else if (it.alert_level == 3 && row_trusted[slot] &&
									row_score[slot] >= CRIT_Q && (it.technique == TECH_BRUTE ||
									it.technique == TECH_DECODE || it.technique == TECH_DOS))
								r.suppress = 1;
						end
						if (row_trusted[slot]) r.boost_code = 2'd3;
						else if (row_partial[slot]) r.boost_code = 2'd2;
						else if (tenant_ema >= TENANT_BOOST_Q && tenant_samples > 32'(min_count))
							r.boost_code = 2'd1;
					end
				end
				CMD_NOTE_ALR: if (it.key_valid) begin
					slot = lookup(it.key_high, it.key_low, it.now_seconds);
					if (slot >= 0) begin
						prod = 64'(row_score[slot]) * 64'd55706 + 64'd32768;
						row_score[slot] = prod[32:16] < FLOOR_Q ? FLOOR_Q : prod[32:16];
						row_partial[slot] = 0;
						row_trusted[slot] = 0;
					end
				end
				default: begin
					if (it.key_valid) slot = lookup(it.key_high, it.key_low, it.now_seconds);
					if (sup_total != 32'hFFFFFFFF) sup_total++;
				end
			endcase
			r.entry_found = slot >= 0;
			if (slot >= 0) begin
				r.trusted_flag = en && row_trusted[slot];
				r.partial_flag = row_partial[slot];
				r.clean_score = row_score[slot];
			end
			r.tenant_score = tenant_ema;
			r.suppressed_count = sup_total;
			pending_results.push_back(r);
		endfunction

		task check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				report("unexpected transfer", 0, 0);
				return;
			end
			want = pending_results.pop_front();
			if (got.entry_found !== want.entry_found)
				report("entry_found", got.entry_found, want.entry_found);
			if (got.suppress !== want.suppress) report("suppress", got.suppress, want.suppress);
			if (got.boost_code !== want.boost_code)
				report("boost_code", got.boost_code, want.boost_code);
			if (got.trusted_flag !== want.trusted_flag)
				report("trusted_flag", got.trusted_flag, want.trusted_flag);
			if (got.partial_flag !== want.partial_flag)
				report("partial_flag", got.partial_flag, want.partial_flag);
			if (got.clean_score !== want.clean_score)
				report("clean_score", got.clean_score, want.clean_score);
			if (got.tenant_score !== want.tenant_score)
				report("tenant_score", got.tenant_score, want.tenant_score);
			if (got.suppressed_count !== want.suppressed_count)
				report("suppressed_count", got.suppressed_count, want.suppressed_count);
		endtask
	endclass

	TrustScoreboard trust_sb = new();
	bit no_idle = 0;
	bit [63:0] key_pool_hi [48];
	bit [63:0] key_pool_lo [48];
	bit [39:0] wall_clock = 40'd1000000;

	// check every result transfer
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) trust_sb.check_result(result);
	end

	function in_item_t make_item(cmd_t c, bit [63:0] hi, bit [63:0] lo, bit v, bit [39:0] now,
			bit [9:0] st, bit [1:0] lvl, bit [13:0] tech, bit ns);
		in_item_t it;
		it.command = c;
		it.key_high = hi;
		it.key_low = lo;
		it.key_valid = v;
		it.now_seconds = now;
		it.status_code = st;
		it.alert_level = lvl;
		it.technique = tech;
		it.never_suppress = ns;
		return it;
	endfunction

	// present one item and hold it until the block takes it
	task send_item(in_item_t it);
		if (!no_idle && $urandom_range(0, 99) < 8)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		@(negedge clk);
		while (busy) @(negedge clk);
		start = 1'b1;
		item = it;
		trust_sb.note_item(it);
		@(negedge clk);
		start = 1'b0;
		item = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
	endtask

	task drain;
		int guard;
		guard = 0;
		while (trust_sb.pending_results.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (30) @(negedge clk);
	endtask

	// write one register while the block is idle
	task write_reg(logic [1:0] idx, logic [15:0] val);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_ENABLE: trust_sb.en = val[0];
			REG_AGE: trust_sb.age_days = val;
			default: trust_sb.min_count = val;
		endcase
	endtask

	task set_mode(bit e, bit [15:0] age, bit [15:0] cnt);
		write_reg(REG_ENABLE, {15'd0, e});
		write_reg(REG_AGE, age);
		write_reg(REG_MINCNT, cnt);
	endtask

	function bit [9:0] pick_status;
		case ($urandom_range(0, 9))
			0: return 10'($urandom_range(0, 999));
			1: return 10'($urandom_range(500, 999));
			2: return 10'd404;
			default: return 10'($urandom_range(200, 399));
		endcase
	endfunction

	task random_phase(int n);
		int k, sel;
		cmd_t c;
		bit [63:0] hi, lo;
		bit v;
		bit [13:0] tech;
		for (int i = 0; i < n; i++) begin
			if (i % 200 == 0) no_idle = (i % 400 == 200);
			// advance time, with an occasional jump or step backwards
			sel = $urandom_range(0, 99);
			if (sel < 3) wall_clock = 40'({$urandom, $urandom});
			else if (sel < 5) wall_clock = wall_clock - $urandom_range(0, 200000);
			else wall_clock = wall_clock + $urandom_range(0, 50000);
			sel = $urandom_range(0, 99);
			c = sel < 55 ? CMD_OBSERVE : sel < 80 ? CMD_CHECK : sel < 90 ? CMD_NOTE_ALR
				: CMD_NOTE_SUP;
			k = $urandom_range(0, 47);
			hi = key_pool_hi[k];
			lo = key_pool_lo[k];
			v = 1;
			sel = $urandom_range(0, 99);
			if (sel < 10) begin
				hi = {$urandom, $urandom};
				lo = {$urandom, $urandom};
			end else if (sel < 15) begin
				v = 0;
				hi = {$urandom, $urandom};
			end
			sel = $urandom_range(0, 3);
			tech = sel == 0 ? TECH_BRUTE : sel == 1 ? TECH_DECODE : sel == 2 ? TECH_DOS
				: 14'($urandom_range(0, 9999));
			send_item(make_item(c, hi, lo, v, wall_clock, pick_status(),
				2'($urandom_range(0, 3)), tech, $urandom_range(0, 4) == 0));
		end
	endtask

	initial begin
		bit [63:0] ka, kb;
		for (int i = 0; i < 48; i++) begin
			key_pool_hi[i] = {$urandom, $urandom};
			key_pool_lo[i] = {$urandom, $urandom};
		end
		key_pool_hi[0] = '0;
		key_pool_lo[0] = '0;
		key_pool_hi[1] = '1;
		key_pool_lo[1] = '1;
		ka = key_pool_hi[2];
		kb = key_pool_lo[2];
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		while (busy) @(negedge clk);

		// disabled block: observe and check insert nothing, notes still work
		send_item(make_item(CMD_OBSERVE, ka, kb, 1, 40'd100, 10'd200, 0, 0, 0));
		send_item(make_item(CMD_CHECK, ka, kb, 1, 40'd100, 10'd0, 2'd1, 0, 0));
		send_item(make_item(CMD_NOTE_ALR, ka, kb, 1, 40'd100, 10'd0, 0, 0, 0));
		send_item(make_item(CMD_NOTE_SUP, '0, '0, 0, 40'd100, 10'd0, 0, 0, 0));
		send_item(make_item(CMD_NOTE_SUP, '1, '1, 1, '1, 10'd999, 2'd3, 14'd9999, 1));

		// minimum count of zero, age waived
		set_mode(1, 16'd0, 16'd0);
		send_item(make_item(CMD_OBSERVE, '0, '0, 1, 40'd0, 10'd200, 0, 0, 0));
		send_item(make_item(CMD_OBSERVE, '0, '0, 0, 40'd0, 10'd200, 0, 0, 0));
		send_item(make_item(CMD_CHECK, '0, '0, 1, 40'd5, 10'd0, 2'd3, TECH_BRUTE, 0));
		send_item(make_item(CMD_CHECK, '0, '0, 1, 40'd5, 10'd0, 2'd2, 0, 1));
		send_item(make_item(CMD_CHECK, '0, '0, 1, 40'd5, 10'd0, 2'd0, 0, 0));
		send_item(make_item(CMD_NOTE_ALR, '0, '0, 1, 40'd6, 10'd0, 0, 0, 0));
		for (int i = 0; i < 12; i++)
			send_item(make_item(CMD_NOTE_ALR, '0, '0, 1, 40'd6, 10'd0, 0, 0, 0));
		send_item(make_item(CMD_OBSERVE, ka, kb, 1, 40'd7, 10'd401, 0, 0, 0));
		send_item(make_item(CMD_OBSERVE, ka, kb, 1, 40'd7, 10'd500, 0, 0, 0));
		send_item(make_item(CMD_OBSERVE, ka, kb, 1, 40'd7, 10'd100, 0, 0, 0));

		// first-seen of zero and a clock that runs backwards fail the age test
		set_mode(1, 16'd1, 16'd1);
		send_item(make_item(CMD_OBSERVE, '0, '0, 1, 40'd900000, 10'd200, 0, 0, 0));
		send_item(make_item(CMD_OBSERVE, ka, kb, 1, 40'd3, 10'd200, 0, 0, 0));
		send_item(make_item(CMD_OBSERVE, ka, kb, 1, 40'd2, 10'd200, 0, 0, 0));

		random_phase(380);
		set_mode(1, 16'd1, 16'd6);
		random_phase(380);
		set_mode(1, 16'd65535, 16'd65535);
		random_phase(150);
		set_mode(1, 16'd30, 16'd1);
		random_phase(200);
		set_mode(0, 16'd0, 16'd2);
		random_phase(120);

		drain();
		if (trust_sb.pending_results.size() != 0)
			trust_sb.report("results missing", trust_sb.pending_results.size(), 0);
		if (trust_sb.errors == 0) $display("PASS per_key_trust_ema_table");
		else $display("FAIL per_key_trust_ema_table");
		$finish;
	end

	// stop a hung run
	initial begin
		#30ms;
		$display("FAIL per_key_trust_ema_table");
		$finish;
	end

endmodule
